### rtl/dslvc_pkg.sv
// ----------------------------------------------------------------------------
// dslvc_pkg
// Shared types and constants of the deadman-gated, slew-limited three-axis
// velocity command core.
// ----------------------------------------------------------------------------
package dslvc_pkg;

  // Field widths.
  localparam int NumAxes  = 3;
  localparam int AxisW    = 2;
  localparam int StickW   = 16;
  localparam int SpeedW   = 15;
  localparam int FactorW  = 10;
  localparam int CmdW     = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 15;

  // Boost factor that stands for one (unsigned Q2.8).
  localparam logic [FactorW-1:0] UnityFactor = 10'd256;

  // Register reset values.
  localparam logic [SpeedW-1:0]  MaxSpeedXRst    = 15'd1229;
  localparam logic [SpeedW-1:0]  MaxSpeedYRst    = 15'd819;
  localparam logic [SpeedW-1:0]  MaxSpeedTurnRst = 15'd1229;
  localparam logic [SpeedW-1:0]  StepLimitRst    = 15'd102;
  localparam logic [FactorW-1:0] BoostRst        = 10'd384;

  // Register indexes of the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    REG_MAX_SPEED_X    = 3'd0,
    REG_MAX_SPEED_Y    = 3'd1,
    REG_MAX_SPEED_TURN = 3'd2,
    REG_STEP_LIMIT_X   = 3'd3,
    REG_STEP_LIMIT_Y   = 3'd4,
    REG_STEP_LIMIT_TURN = 3'd5,
    REG_BOOST_FACTOR   = 3'd6
  } dslvc_reg_e;

  // Operation of the shared multiplier.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SPEED  = 2'd1,
    OP_FACTOR = 2'd2
  } dslvc_op_e;

  // Control from the sequencer to the slew unit.
  typedef struct packed {
    dslvc_op_e op;
  } dslvc_ctrl_t;

  // Operands of the axis being worked on.
  typedef struct packed {
    logic [StickW-1:0]  stick;
    logic [SpeedW-1:0]  speed;
    logic [FactorW-1:0] factor;
    logic [SpeedW-1:0]  step;
    logic [CmdW-1:0]    prev;
  } dslvc_operand_t;

endpackage

### rtl/dslvc_slew_unit.sv
// ----------------------------------------------------------------------------
// dslvc_slew_unit
// Shared signed multiplier with product register, followed by the rounding,
// slew limiter and 16-bit saturation of one axis.
// ----------------------------------------------------------------------------
module dslvc_slew_unit (
  input  logic                      clk_i,
  input  dslvc_pkg::dslvc_ctrl_t    ctrl_i,
  input  dslvc_pkg::dslvc_operand_t opnd_i,
  output logic [dslvc_pkg::CmdW-1:0] cmd_o
);
  import dslvc_pkg::*;

  logic signed [30:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [46:0] mul_full;
  logic        [40:0] prod_q;

  logic signed [18:0] req;
  logic signed [19:0] diff;
  logic signed [19:0] step_pos;
  logic signed [19:0] step_neg;
  logic signed [17:0] up_val;
  logic signed [17:0] dn_val;
  logic signed [18:0] lim;

  // Operand selection: stick times speed first, then that product times factor.
  always_comb begin
    case (ctrl_i.op)
      OP_SPEED: begin
        mul_a = {{15{opnd_i.stick[StickW-1]}}, opnd_i.stick};
        mul_b = {1'b0, opnd_i.speed};
      end
      OP_FACTOR: begin
        mul_a = prod_q[30:0];
        mul_b = {6'b0, opnd_i.factor};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // The full product never exceeds 41 signed bits.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op != OP_HOLD) begin
      prod_q <= mul_full[40:0];
    end
  end

  // Scale by 2^-23, rounding to nearest with ties toward plus infinity.
  assign req = $signed({prod_q[40], prod_q[40:23]}) + $signed({18'b0, prod_q[22]});

  // Slew limiter against the previous command.
  assign diff     = $signed({req[18], req}) - $signed({{4{opnd_i.prev[CmdW-1]}}, opnd_i.prev});
  assign step_pos = $signed({5'b0, opnd_i.step});
  assign step_neg = 20'sd0 - step_pos;
  assign up_val   = $signed({{2{opnd_i.prev[CmdW-1]}}, opnd_i.prev}) +
                    $signed({3'b0, opnd_i.step});
  assign dn_val   = $signed({{2{opnd_i.prev[CmdW-1]}}, opnd_i.prev}) -
                    $signed({3'b0, opnd_i.step});

  always_comb begin
    if (diff > step_pos) begin
      lim = {up_val[17], up_val};
    end else if (diff < step_neg) begin
      lim = {dn_val[17], dn_val};
    end else begin
      lim = req;
    end
  end

  // Saturate to the 16-bit command range.
  always_comb begin
    if (lim > 19'sd32767) begin
      cmd_o = 16'h7FFF;
    end else if (lim < -19'sd32768) begin
      cmd_o = 16'h8000;
    end else begin
      cmd_o = lim[CmdW-1:0];
    end
  end

endmodule

### rtl/deadman_slew_limited_velocity_command_core.sv
// Sequence: an active tick passes, axis by axis, through S_MUL1 and S_MUL2 on the
// one shared multiplier and S_LIM on the limiter; S_OUT then loads the result.
// A released tick after an active one goes straight to S_OUT with zero commands;
// further released ticks give nothing and leave the input ready.
// Flow: the input is ready only when idle; no tick is taken while one is in work.
// Reset: registers take their defaults, commands clear to zero, block is stopped.
// ----------------------------------------------------------------------------
// deadman_slew_limited_velocity_command_core
// Deadman-gated joystick to velocity command converter with per-axis scaling,
// optional boost and slew limiting, built around one shared multiplier.
// ----------------------------------------------------------------------------
module deadman_slew_limited_velocity_command_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [dslvc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [dslvc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // Joystick samples.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // stick_x, stick_y, stick_turn
  input  logic [1:0]                        s_axis_tuser,  // deadman_held, run_held
  // Velocity commands.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata   // cmd_x, cmd_y, cmd_turn
);
  import dslvc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL1 = 5'b00010,
    S_MUL2 = 5'b00100,
    S_LIM  = 5'b01000,
    S_OUT  = 5'b10000
  } dslvc_state_e;

  localparam logic [AxisW-1:0] AxisLast = AxisW'(NumAxes - 1);

  dslvc_state_e state_q, state_d;
  logic [AxisW-1:0]   axis_q;
  logic               halted_q;
  logic [CmdW-1:0]    prev_q [NumAxes];
  logic [StickW-1:0]  stick_q [NumAxes];
  logic [FactorW-1:0] factor_q;
  logic [SpeedW-1:0]  max_speed_q [NumAxes];
  logic [SpeedW-1:0]  step_limit_q [NumAxes];
  logic [FactorW-1:0] boost_q;
  logic               out_valid_q;
  logic [47:0]        out_data_q;

  logic               in_fire;
  logic               deadman;
  logic               out_load;
  dslvc_ctrl_t        ctrl;
  dslvc_operand_t     opnd;
  logic [CmdW-1:0]    lim_cmd;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign deadman       = s_axis_tuser[0];
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q[0]  <= MaxSpeedXRst;
      max_speed_q[1]  <= MaxSpeedYRst;
      max_speed_q[2]  <= MaxSpeedTurnRst;
      step_limit_q[0] <= StepLimitRst;
      step_limit_q[1] <= StepLimitRst;
      step_limit_q[2] <= StepLimitRst;
      boost_q         <= BoostRst;
    end else if (cfg_we_i) begin
      case (dslvc_reg_e'(cfg_addr_i))
        REG_MAX_SPEED_X:     max_speed_q[0]  <= cfg_wdata_i;
        REG_MAX_SPEED_Y:     max_speed_q[1]  <= cfg_wdata_i;
        REG_MAX_SPEED_TURN:  max_speed_q[2]  <= cfg_wdata_i;
        REG_STEP_LIMIT_X:    step_limit_q[0] <= cfg_wdata_i;
        REG_STEP_LIMIT_Y:    step_limit_q[1] <= cfg_wdata_i;
        REG_STEP_LIMIT_TURN: step_limit_q[2] <= cfg_wdata_i;
        REG_BOOST_FACTOR:    boost_q         <= cfg_wdata_i[FactorW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (deadman) begin
            state_d = S_MUL1;
          end else if (!halted_q) begin
            state_d = S_OUT;
          end
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_LIM;
      S_LIM: begin
        state_d = (axis_q == AxisLast) ? S_OUT : S_MUL1;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, previous commands and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      halted_q    <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (deadman) begin
          axis_q   <= '0;
          halted_q <= 1'b0;
        end else if (!halted_q) begin
          halted_q <= 1'b1;
          for (int i = 0; i < NumAxes; i++) begin
            prev_q[i] <= '0;
          end
        end
      end
      if (state_q == S_LIM) begin
        prev_q[axis_q] <= lim_cmd;
        if (axis_q != AxisLast) begin
          axis_q <= axis_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Captured sample and the output payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stick_q[0] <= s_axis_tdata[15:0];
      stick_q[1] <= s_axis_tdata[31:16];
      stick_q[2] <= s_axis_tdata[47:32];
      factor_q   <= s_axis_tuser[1] ? boost_q : UnityFactor;
    end
    if (out_load) begin
      out_data_q <= {prev_q[2], prev_q[1], prev_q[0]};
    end
  end

  // Operands of the current axis for the shared unit.
  always_comb begin
    case (state_q)
      S_MUL1:  ctrl.op = OP_SPEED;
      S_MUL2:  ctrl.op = OP_FACTOR;
      default: ctrl.op = OP_HOLD;
    endcase
    opnd.stick  = stick_q[axis_q];
    opnd.speed  = max_speed_q[axis_q];
    opnd.factor = factor_q;
    opnd.step   = step_limit_q[axis_q];
    opnd.prev   = prev_q[axis_q];
  end

  dslvc_slew_unit u_slew (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .opnd_i (opnd),
    .cmd_o  (lim_cmd)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // The axis counter never runs past the last axis.
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q <= AxisLast)
    else $error("axis counter out of range");

  // A stopped block always holds zero commands.
  a_halted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (prev_q[0] == '0 && prev_q[1] == '0 && prev_q[2] == '0))
    else $error("stopped block holds a nonzero command");

  // The last axis is followed by the output stage.
  a_last_axis_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIM && axis_q == AxisLast) |=> state_q == S_OUT)
    else $error("last axis not followed by output");

  // A released tick after an active one goes to the output stage with the block stopped.
  a_release_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !deadman && !halted_q) |=> (state_q == S_OUT && halted_q))
    else $error("deadman release did not stop the block");
`endif

endmodule
